// ----- sv/vehicle_health_mode_supervisor_macros.svh -----
// Assertion macros shared by the vehicle health mode supervisor RTL.
`ifndef VEHICLE_HEALTH_MODE_SUPERVISOR_MACROS_SVH
`define VEHICLE_HEALTH_MODE_SUPERVISOR_MACROS_SVH

`ifndef ASSERT_OFF
// Check a property on the rising clock edge, masked while reset is low.
`define VHMS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("vhms assertion failed");
// Check a property on the rising clock edge, also during reset.
`define VHMS_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("vhms assertion failed");
`else
`define VHMS_ASSERT(lbl, clk, rst_n, prop)
`define VHMS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- sv/vhms_pkg.sv -----
// Types, codes and reset constants of the vehicle health mode supervisor.
`default_nettype none

package vhms_pkg;

  // System mode codes
  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_ERROR   = 2'd2
  } mode_e;

  // Item kinds carried on tuser
  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_BATT  = 3'd1,
    KIND_TEMP  = 3'd2,
    KIND_GPS   = 3'd3,
    KIND_LINK  = 3'd4,
    KIND_ESTOP = 3'd5,
    KIND_TASK  = 3'd6
  } kind_e;

  // Link levels
  typedef enum logic [1:0] {
    LINK_CONN = 2'd0,
    LINK_LOW  = 2'd1,
    LINK_LOST = 2'd2
  } link_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_INIT_TIME  = 3'd0,
    REG_STALE_TO   = 3'd1,
    REG_BATT_LOW   = 3'd2,
    REG_TEMP_HIGH  = 3'd3,
    REG_GPS_BAD    = 3'd4,
    REG_GPS_HOLD   = 3'd5,
    REG_LOW_HOLD   = 3'd6,
    REG_LOST_HOLD  = 3'd7
  } cfg_reg_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned NumCause = 7;

  // Error cause bit positions
  localparam int unsigned CauseStale = 0;
  localparam int unsigned CauseBatt  = 1;
  localparam int unsigned CauseTemp  = 2;
  localparam int unsigned CauseGps   = 3;
  localparam int unsigned CauseLow   = 4;
  localparam int unsigned CauseLost  = 5;
  localparam int unsigned CauseEstop = 6;

  // Reset values of the hold times in ms
  localparam logic [31:0] GpsHoldRst  = 32'd15000;
  localparam logic [31:0] LowHoldRst  = 32'd20000;
  localparam logic [31:0] LostHoldRst = 32'd10000;

  // Result beat, mode in the lowest bits
  typedef struct packed {
    logic [NumCause-1:0] causes;
    logic                error_now;
    mode_e               mode;
  } result_t;

  // True when the wrapped age of a stamp exceeds a limit
  function automatic logic aged(logic [31:0] now, logic [31:0] stamp, logic [31:0] limit);
    logic [31:0] age;
    age = now - stamp;
    return age > limit;
  endfunction

endpackage

`default_nettype wire

// ----- sv/vehicle_health_mode_supervisor.sv -----
// Vehicle health mode supervisor: sensor state, error causes and mode per input beat.
//
// Takes one beat per clock and returns one result beat per input beat, registered
// in the cycle after it is accepted. All per-beat work (state update, five stale
// stamp ages, GPS good and link connected ages, level compares, mode decision)
// sits between the sensor state registers and the result register, so the rate
// is one beat per cycle; the result register lets the next input beat in while a
// result is taken, and s_axis_tready only drops when the result register is full
// and m_axis_tready is low. Configuration writes take effect at the edge where
// cfg_we_i is high and must come while no beat is in flight; writing init_time_ms
// also reloads the last GPS good and last link connected times.
`default_nettype none
`include "vehicle_health_mode_supervisor_macros.svh"

module vehicle_health_mode_supervisor (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration write port
  input  wire logic                           cfg_we_i,
  input  wire logic [vhms_pkg::CfgIdxW-1:0]   cfg_addr_i,
  input  wire logic [vhms_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [63:0]                    s_axis_tdata,  // time_ms[31:0], value[63:32]
  input  wire logic [2:0]                     s_axis_tuser,  // kind[2:0]
  // result stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [15:0]                         m_axis_tdata   // system_mode[1:0],
                                                             // error_now[2],
                                                             // error_causes[9:3]
);

  // configuration registers
  logic [31:0]        stale_to_q, gps_hold_q, low_hold_q, lost_hold_q;
  logic signed [31:0] batt_low_q, temp_high_q, gps_bad_q;

  // sensor state
  logic signed [31:0] batt_val_q, batt_val_d, temp_val_q, temp_val_d;
  logic signed [31:0] gps_val_q, gps_val_d;
  logic [31:0]        batt_stamp_q, batt_stamp_d, temp_stamp_q, temp_stamp_d;
  logic [31:0]        gps_stamp_q, gps_stamp_d, link_stamp_q, link_stamp_d;
  logic [31:0]        estop_stamp_q, estop_stamp_d;
  logic [31:0]        gps_good_q, gps_good_d, link_conn_q, link_conn_d;
  vhms_pkg::link_e    link_q, link_d;
  logic               estop_q, estop_d, task_q, task_d;
  vhms_pkg::mode_e    mode_q, mode_d;

  // result register
  logic               out_valid_q;
  vhms_pkg::result_t  out_q;

  // input beat fields
  vhms_pkg::kind_e    kind;
  logic [31:0]        now;
  logic signed [31:0] value;
  logic               s_fire;
  logic [vhms_pkg::NumCause-1:0] causes;

  assign kind   = vhms_pkg::kind_e'(s_axis_tuser);
  assign now    = s_axis_tdata[31:0];
  assign value  = $signed(s_axis_tdata[63:32]);
  assign s_fire = s_axis_tvalid && s_axis_tready;

  // Accept while the result register is empty or being drained
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_q};

  // Apply the beat's update to the sensor state
  always_comb begin
    batt_val_d    = batt_val_q;
    batt_stamp_d  = batt_stamp_q;
    temp_val_d    = temp_val_q;
    temp_stamp_d  = temp_stamp_q;
    gps_val_d     = gps_val_q;
    gps_stamp_d   = gps_stamp_q;
    gps_good_d    = gps_good_q;
    link_d        = link_q;
    link_stamp_d  = link_stamp_q;
    link_conn_d   = link_conn_q;
    estop_d       = estop_q;
    estop_stamp_d = estop_stamp_q;
    task_d        = task_q;
    unique case (kind)
      vhms_pkg::KIND_BATT: begin
        batt_val_d   = value;
        batt_stamp_d = now;
      end
      vhms_pkg::KIND_TEMP: begin
        temp_val_d   = value;
        temp_stamp_d = now;
      end
      vhms_pkg::KIND_GPS: begin
        gps_val_d   = value;
        gps_stamp_d = now;
        if (!(value > gps_bad_q)) begin
          gps_good_d = now;
        end
      end
      vhms_pkg::KIND_LINK: begin
        link_stamp_d = now;
        if (value == 32'sd0) begin
          link_d      = vhms_pkg::LINK_CONN;
          link_conn_d = now;
        end else if (value == 32'sd1) begin
          link_d = vhms_pkg::LINK_LOW;
        end else begin
          link_d = vhms_pkg::LINK_LOST;
        end
      end
      vhms_pkg::KIND_ESTOP: begin
        estop_d       = (value != 32'sd0);
        estop_stamp_d = now;
      end
      vhms_pkg::KIND_TASK: begin
        task_d = (value != 32'sd0);
      end
      default: begin
      end
    endcase
  end

  // Evaluate the error causes on the updated state at the beat's time
  always_comb begin
    causes = '0;
    causes[vhms_pkg::CauseStale] = (stale_to_q != 32'd0) && (
      vhms_pkg::aged(now, batt_stamp_d, stale_to_q) ||
      vhms_pkg::aged(now, temp_stamp_d, stale_to_q) ||
      vhms_pkg::aged(now, gps_stamp_d, stale_to_q) ||
      vhms_pkg::aged(now, link_stamp_d, stale_to_q) ||
      vhms_pkg::aged(now, estop_stamp_d, stale_to_q));
    causes[vhms_pkg::CauseBatt] = batt_val_d < batt_low_q;
    causes[vhms_pkg::CauseTemp] = temp_val_d > temp_high_q;
    causes[vhms_pkg::CauseGps]  = (gps_val_d > gps_bad_q) &&
                                  vhms_pkg::aged(now, gps_good_d, gps_hold_q);
    causes[vhms_pkg::CauseLow]  = (link_d == vhms_pkg::LINK_LOW) &&
                                  vhms_pkg::aged(now, link_conn_d, low_hold_q);
    causes[vhms_pkg::CauseLost] = (link_d == vhms_pkg::LINK_LOST) &&
                                  vhms_pkg::aged(now, link_conn_d, lost_hold_q);
    causes[vhms_pkg::CauseEstop] = estop_d;
  end

  // Decide the mode; only a tick moves it
  always_comb begin
    mode_d = mode_q;
    if (kind == vhms_pkg::KIND_TICK) begin
      if (causes != '0) begin
        mode_d = vhms_pkg::MODE_ERROR;
      end else if (task_d) begin
        mode_d = vhms_pkg::MODE_RUNNING;
      end else begin
        mode_d = vhms_pkg::MODE_IDLE;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_to_q  <= '0;
      batt_low_q  <= '0;
      temp_high_q <= '0;
      gps_bad_q   <= '0;
      gps_hold_q  <= vhms_pkg::GpsHoldRst;
      low_hold_q  <= vhms_pkg::LowHoldRst;
      lost_hold_q <= vhms_pkg::LostHoldRst;
    end else if (cfg_we_i) begin
      unique case (vhms_pkg::cfg_reg_e'(cfg_addr_i))
        vhms_pkg::REG_INIT_TIME: begin
          // only the good and connected times take this value
        end
        vhms_pkg::REG_STALE_TO:  stale_to_q  <= cfg_wdata_i;
        vhms_pkg::REG_BATT_LOW:  batt_low_q  <= $signed(cfg_wdata_i);
        vhms_pkg::REG_TEMP_HIGH: temp_high_q <= $signed(cfg_wdata_i);
        vhms_pkg::REG_GPS_BAD:   gps_bad_q   <= $signed(cfg_wdata_i);
        vhms_pkg::REG_GPS_HOLD:  gps_hold_q  <= cfg_wdata_i;
        vhms_pkg::REG_LOW_HOLD:  low_hold_q  <= cfg_wdata_i;
        vhms_pkg::REG_LOST_HOLD: lost_hold_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Sensor state and mode; init time write reloads the good/connected times
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batt_val_q    <= '0;
      batt_stamp_q  <= '0;
      temp_val_q    <= '0;
      temp_stamp_q  <= '0;
      gps_val_q     <= '0;
      gps_stamp_q   <= '0;
      gps_good_q    <= '0;
      link_q        <= vhms_pkg::LINK_CONN;
      link_stamp_q  <= '0;
      link_conn_q   <= '0;
      estop_q       <= 1'b0;
      estop_stamp_q <= '0;
      task_q        <= 1'b0;
      mode_q        <= vhms_pkg::MODE_IDLE;
    end else if (s_fire) begin
      batt_val_q    <= batt_val_d;
      batt_stamp_q  <= batt_stamp_d;
      temp_val_q    <= temp_val_d;
      temp_stamp_q  <= temp_stamp_d;
      gps_val_q     <= gps_val_d;
      gps_stamp_q   <= gps_stamp_d;
      gps_good_q    <= gps_good_d;
      link_q        <= link_d;
      link_stamp_q  <= link_stamp_d;
      link_conn_q   <= link_conn_d;
      estop_q       <= estop_d;
      estop_stamp_q <= estop_stamp_d;
      task_q        <= task_d;
      mode_q        <= mode_d;
    end else if (cfg_we_i &&
                 vhms_pkg::cfg_reg_e'(cfg_addr_i) == vhms_pkg::REG_INIT_TIME) begin
      gps_good_q  <= cfg_wdata_i;
      link_conn_q <= cfg_wdata_i;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_fire) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      out_q.mode      <= mode_d;
      out_q.error_now <= (causes != '0);
      out_q.causes    <= causes;
    end
  end

  `VHMS_ASSERT(a_err_matches_causes, clk_i, rst_ni,
    out_valid_q |-> (out_q.error_now == (out_q.causes != '0)))
  `VHMS_ASSERT(a_out_mode_tracks_state, clk_i, rst_ni,
    s_fire |=> (out_q.mode == mode_q))
  `VHMS_ASSERT(a_update_keeps_mode, clk_i, rst_ni,
    (s_fire && kind != vhms_pkg::KIND_TICK) |=> $stable(mode_q))
  `VHMS_ASSERT(a_clean_tick_idle, clk_i, rst_ni,
    (s_fire && kind == vhms_pkg::KIND_TICK && causes == '0 && !task_d)
      |=> (mode_q == vhms_pkg::MODE_IDLE))
  `VHMS_ASSERT(a_init_reloads_times, clk_i, rst_ni,
    (cfg_we_i && !s_fire &&
     vhms_pkg::cfg_reg_e'(cfg_addr_i) == vhms_pkg::REG_INIT_TIME)
      |=> (gps_good_q == $past(cfg_wdata_i) && link_conn_q == $past(cfg_wdata_i)))
  `VHMS_ASSERT_ALWAYS(a_no_result_in_reset, clk_i,
    !rst_ni |-> !out_valid_q)

endmodule

`default_nettype wire

// ----- tb/sv/vehicle_health_mode_supervisor_checker.sv -----
// Scoreboard that predicts and checks every result beat of the vehicle health mode supervisor.

module vehicle_health_mode_supervisor_checker
  import vhms_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_addr_i,
  input  wire logic [CfgDataW-1:0] cfg_wdata_i,
  input  wire logic                s_axis_tvalid,
  input  wire logic                s_axis_tready,
  input  wire logic [63:0]         s_axis_tdata,  // time_ms[31:0], value[63:32]
  input  wire logic [2:0]          s_axis_tuser,  // kind[2:0]
  input  wire logic                m_axis_tvalid,
  input  wire logic                m_axis_tready,
  input  wire logic [15:0]         m_axis_tdata,  // system_mode[1:0], error_now[2],
                                                  // error_causes[9:3]
  output int                       fail_count_o,
  output int                       pending_o
);

  // Shadow of the configuration registers
  logic [31:0]        cfg_init;
  logic [31:0]        cfg_stale;
  logic signed [31:0] cfg_batt;
  logic signed [31:0] cfg_temp;
  logic signed [31:0] cfg_gps;
  logic [31:0]        cfg_gps_hold;
  logic [31:0]        cfg_low_hold;
  logic [31:0]        cfg_lost_hold;

  // Shadow of the sensor state
  logic signed [31:0] batt_lvl;
  logic [31:0]        batt_ts;
  logic signed [31:0] temp_lvl;
  logic [31:0]        temp_ts;
  logic signed [31:0] gps_acc;
  logic [31:0]        gps_ts;
  link_e              link_state;
  logic [31:0]        link_ts;
  logic               estop_on;
  logic [31:0]        estop_ts;
  logic               task_on;
  logic [31:0]        gps_good_ts;
  logic [31:0]        link_conn_ts;
  mode_e              cur_mode;

  // Status beats still owed by the block, oldest first
  result_t awaited_status[$];

  // Wrapped age of a stamp compared against a limit
  function automatic logic age_over(logic [31:0] now, logic [31:0] ts, logic [31:0] lim);
    logic [31:0] diff;
    diff = now - ts;
    return diff > lim;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("health check: %s mismatch, got %0h want %0h", what, got, want);
    fail_count_o++;
  endtask

  task automatic write_cfg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    case (idx)
      REG_INIT_TIME: begin
        cfg_init     = data;
        gps_good_ts  = data;
        link_conn_ts = data;
      end
      REG_STALE_TO:  cfg_stale     = data;
      REG_BATT_LOW:  cfg_batt      = data;
      REG_TEMP_HIGH: cfg_temp      = data;
      REG_GPS_BAD:   cfg_gps       = data;
      REG_GPS_HOLD:  cfg_gps_hold  = data;
      REG_LOW_HOLD:  cfg_low_hold  = data;
      REG_LOST_HOLD: cfg_lost_hold = data;
      default: ;
    endcase
  endtask

  // Apply one input beat to the shadow state and work out its status beat
  task automatic update_health(input logic [2:0] kind, input logic [31:0] now,
                               input logic signed [31:0] val, output result_t res);
    logic [NumCause-1:0] c;
    case (kind)
      KIND_BATT: begin
        batt_lvl = val;
        batt_ts  = now;
      end
      KIND_TEMP: begin
        temp_lvl = val;
        temp_ts  = now;
      end
      KIND_GPS: begin
        gps_acc = val;
        gps_ts  = now;
        if (!(val > cfg_gps)) gps_good_ts = now;
      end
      KIND_LINK: begin
        link_ts = now;
        if (val == 0) begin
          link_state   = LINK_CONN;
          link_conn_ts = now;
        end else if (val == 1) begin
          link_state = LINK_LOW;
        end else begin
          // saturate any other level to lost
          link_state = LINK_LOST;
        end
      end
      KIND_ESTOP: begin
        estop_on = (val != 0);
        estop_ts = now;
      end
      KIND_TASK: task_on = (val != 0);
      default: ;
    endcase

    c = '0;
    if (cfg_stale != 0 && (age_over(now, batt_ts, cfg_stale) ||
                           age_over(now, temp_ts, cfg_stale) ||
                           age_over(now, gps_ts, cfg_stale) ||
                           age_over(now, link_ts, cfg_stale) ||
                           age_over(now, estop_ts, cfg_stale)))
      c[CauseStale] = 1'b1;
    if (batt_lvl < cfg_batt) c[CauseBatt] = 1'b1;
    if (temp_lvl > cfg_temp) c[CauseTemp] = 1'b1;
    if (gps_acc > cfg_gps && age_over(now, gps_good_ts, cfg_gps_hold)) c[CauseGps] = 1'b1;
    if (link_state == LINK_LOW && age_over(now, link_conn_ts, cfg_low_hold))
      c[CauseLow] = 1'b1;
    if (link_state == LINK_LOST && age_over(now, link_conn_ts, cfg_lost_hold))
      c[CauseLost] = 1'b1;
    if (estop_on) c[CauseEstop] = 1'b1;

    // only a tick moves the mode
    if (kind == KIND_TICK) begin
      if (c != '0)      cur_mode = MODE_ERROR;
      else if (task_on) cur_mode = MODE_RUNNING;
      else              cur_mode = MODE_IDLE;
    end

    res.mode      = cur_mode;
    res.error_now = (c != '0);
    res.causes    = c;
  endtask

  task automatic check_status(input result_t got);
    result_t want;
    if (awaited_status.size() == 0) begin
      report_mismatch("unexpected status beat", got, 0);
    end else begin
      want = awaited_status.pop_front();
      if (got.mode != want.mode) report_mismatch("system_mode", got.mode, want.mode);
      if (got.error_now != want.error_now)
        report_mismatch("error_now", got.error_now, want.error_now);
      if (got.causes != want.causes) report_mismatch("error_causes", got.causes, want.causes);
    end
  endtask

  // Track writes, predict on input beats, compare on output beats
  always @(posedge clk_i or negedge rst_ni) begin
    result_t res;
    if (!rst_ni) begin
      cfg_init      = '0;
      cfg_stale     = '0;
      cfg_batt      = '0;
      cfg_temp      = '0;
      cfg_gps       = '0;
      cfg_gps_hold  = GpsHoldRst;
      cfg_low_hold  = LowHoldRst;
      cfg_lost_hold = LostHoldRst;
      batt_lvl      = '0;
      batt_ts       = '0;
      temp_lvl      = '0;
      temp_ts       = '0;
      gps_acc       = '0;
      gps_ts        = '0;
      link_state    = LINK_CONN;
      link_ts       = '0;
      estop_on      = 1'b0;
      estop_ts      = '0;
      task_on       = 1'b0;
      gps_good_ts   = '0;
      link_conn_ts  = '0;
      cur_mode      = MODE_IDLE;
      awaited_status.delete();
      fail_count_o  = 0;
      pending_o     = 0;
    end else begin
      if (cfg_we_i) write_cfg(cfg_addr_i, cfg_wdata_i);
      if (s_axis_tvalid && s_axis_tready) begin
        update_health(s_axis_tuser, s_axis_tdata[31:0], s_axis_tdata[63:32], res);
        awaited_status.push_back(res);
      end
      if (m_axis_tvalid && m_axis_tready) check_status(m_axis_tdata[9:0]);
      pending_o = awaited_status.size();
    end
  end

endmodule

// ----- tb/sv/vehicle_health_mode_supervisor_test.sv -----
// Stimulus, clocking and verdict for the vehicle health mode supervisor testbench.

module vehicle_health_mode_supervisor_test;
  import vhms_pkg::*;

  localparam logic [2:0] KindUnused = 3'd7;
  localparam int QuietLimit = 4000;
  localparam int PhaseBeats = 185;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_addr_i;
  logic [CfgDataW-1:0] cfg_wdata_i;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [63:0]         s_axis_tdata;  // time_ms[31:0], value[63:32]
  logic [2:0]          s_axis_tuser;  // kind[2:0]
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [15:0]         m_axis_tdata;  // system_mode[1:0], error_now[2], error_causes[9:3]

  int          fail_count;
  int          pending;
  int          quiet_cycles = 0;
  int          sender_idle_pct = 0;
  int          sink_stall_pct = 0;
  logic [31:0] reg_val [0:7];
  logic [31:0] now_ms;

  vehicle_health_mode_supervisor DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  vehicle_health_mode_supervisor_checker health_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Stall the result side at random
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  // Count cycles without any beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QuietLimit);
    $display("vehicle_health_mode_supervisor_test: errors");
    $finish;
  end

  // Offer one beat after a random idle gap and hold it until accepted
  task automatic send_beat(input logic [2:0] kind, input logic [31:0] t, input logic [31:0] v);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {v, t};
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Hold the input until every status beat is back
  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  task automatic choose_regs(input int sel);
    case (sel)
      0: begin
        reg_val[REG_INIT_TIME] = '0;
        reg_val[REG_STALE_TO]  = 32'd5000;
        reg_val[REG_BATT_LOW]  = 32'h000A_0000;
        reg_val[REG_TEMP_HIGH] = 32'h003C_0000;
        reg_val[REG_GPS_BAD]   = 32'h0002_0000;
        reg_val[REG_GPS_HOLD]  = GpsHoldRst;
        reg_val[REG_LOW_HOLD]  = LowHoldRst;
        reg_val[REG_LOST_HOLD] = LostHoldRst;
      end
      1: begin
        // widest limits, zero hold times, start just before the wrap
        reg_val[REG_INIT_TIME] = 32'hFFFF_F000;
        reg_val[REG_STALE_TO]  = 32'hFFFF_FFFF;
        reg_val[REG_BATT_LOW]  = 32'h8000_0000;
        reg_val[REG_TEMP_HIGH] = 32'h7FFF_FFFF;
        reg_val[REG_GPS_BAD]   = 32'h7FFF_FFFF;
        reg_val[REG_GPS_HOLD]  = '0;
        reg_val[REG_LOW_HOLD]  = '0;
        reg_val[REG_LOST_HOLD] = '0;
      end
      2: begin
        // tightest levels, endless hold times, stale check off
        reg_val[REG_INIT_TIME] = $urandom;
        reg_val[REG_STALE_TO]  = '0;
        reg_val[REG_BATT_LOW]  = 32'h7FFF_FFFF;
        reg_val[REG_TEMP_HIGH] = 32'h8000_0000;
        reg_val[REG_GPS_BAD]   = 32'h8000_0000;
        reg_val[REG_GPS_HOLD]  = 32'hFFFF_FFFF;
        reg_val[REG_LOW_HOLD]  = 32'hFFFF_FFFF;
        reg_val[REG_LOST_HOLD] = 32'hFFFF_FFFF;
      end
      default: begin
        reg_val[REG_INIT_TIME] = $urandom;
        reg_val[REG_STALE_TO]  = $urandom_range(1, 30000);
        reg_val[REG_BATT_LOW]  = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        reg_val[REG_TEMP_HIGH] = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        reg_val[REG_GPS_BAD]   = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
        reg_val[REG_GPS_HOLD]  = $urandom_range(0, 30000);
        reg_val[REG_LOW_HOLD]  = $urandom_range(0, 30000);
        reg_val[REG_LOST_HOLD] = $urandom_range(0, 30000);
      end
    endcase
  endtask

  // Write every register, then start the clock near the new init time
  task automatic apply_regs();
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_addr_i  <= i[CfgIdxW-1:0];
      cfg_wdata_i <= reg_val[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    now_ms = reg_val[REG_INIT_TIME] + $urandom_range(0, 1000);
  endtask

  // Pick a reading close to a level, now and then anywhere
  function automatic logic [31:0] near_level(input logic [31:0] lvl);
    int r;
    r = $urandom_range(0, 99);
    if (r < 30)      return lvl + $urandom_range(0, 8) - 32'd4;
    else if (r < 75) return lvl + $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    else if (r < 90) return $urandom;
    else if (r < 95) return 32'h8000_0000;
    else             return 32'h7FFF_FFFF;
  endfunction

  // Advance the clock and build one random beat
  task automatic next_random_beat(output logic [2:0] kind, output logic [31:0] t,
                                  output logic [31:0] v);
    int r;
    r = $urandom_range(0, 99);
    if (r < 2)       now_ms = $urandom;
    else if (r < 4)  now_ms -= $urandom_range(1, 5000);
    else if (r < 70) now_ms += $urandom_range(0, 1500);
    else             now_ms += $urandom_range(1500, 24000);

    r = $urandom_range(0, 99);
    if (r < 25)      kind = KIND_TICK;
    else if (r < 27) kind = KindUnused;
    else             kind = 3'($urandom_range(KIND_BATT, KIND_TASK));

    // mostly fresh stamps, some late ones and a few anywhere
    t = now_ms;
    r = $urandom_range(0, 99);
    if (r < 10)      t = now_ms - $urandom_range(0, 30000);
    else if (r < 13) t = $urandom;

    r = $urandom_range(0, 99);
    case (kind)
      KIND_BATT:  v = near_level(reg_val[REG_BATT_LOW]);
      KIND_TEMP:  v = near_level(reg_val[REG_TEMP_HIGH]);
      KIND_GPS:   v = near_level(reg_val[REG_GPS_BAD]);
      KIND_LINK:  v = (r < 80) ? $urandom_range(LINK_CONN, LINK_LOST) : $urandom;
      KIND_ESTOP: v = (r < 75) ? 32'd0 : (r < 90) ? 32'd1 : $urandom;
      KIND_TASK:  v = (r < 75) ? $urandom_range(0, 1) : $urandom;
      default:    v = $urandom;
    endcase
  endtask

  initial begin
    logic [2:0]  kind;
    logic [31:0] t;
    logic [31:0] v;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_addr_i    = '0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    now_ms        = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats with the reset register values
    send_beat(KIND_TICK, 32'd0, 32'd0);
    send_beat(KIND_TASK, 32'd100, 32'd1);
    send_beat(KIND_TICK, 32'd200, 32'd0);
    send_beat(KIND_BATT, 32'd300, 32'hFFFF_FFFF);
    send_beat(KIND_TICK, 32'd400, 32'd0);
    send_beat(KIND_BATT, 32'd500, 32'h7FFF_FFFF);
    send_beat(KIND_TEMP, 32'd600, 32'h8000_0000);
    send_beat(KIND_TEMP, 32'd700, 32'h7FFF_FFFF);
    send_beat(KIND_TEMP, 32'd800, 32'd0);
    // gps bad: error only once the hold time is strictly exceeded
    send_beat(KIND_GPS, 32'd1000, 32'd1);
    send_beat(KIND_TICK, 32'd15000, 32'd0);
    send_beat(KIND_TICK, 32'd15001, 32'd0);
    send_beat(KIND_GPS, 32'd15002, 32'd0);
    // link low, lost, and levels that saturate to lost
    send_beat(KIND_LINK, 32'd16000, 32'd1);
    send_beat(KIND_TICK, 32'd20001, 32'd0);
    send_beat(KIND_LINK, 32'd20002, 32'd2);
    send_beat(KIND_LINK, 32'd20003, 32'hFFFF_FFFB);
    send_beat(KIND_LINK, 32'd20004, 32'd7);
    wait_drain();
    send_beat(KIND_LINK, 32'd21000, 32'd0);
    // any nonzero flag sets the emergency stop
    send_beat(KIND_ESTOP, 32'd21100, 32'h8000_0000);
    send_beat(KIND_TICK, 32'd21200, 32'd0);
    send_beat(KIND_ESTOP, 32'd21300, 32'd0);
    send_beat(KindUnused, 32'hFFFF_FFFF, 32'h1234_5678);
    send_beat(KIND_TASK, 32'hFFFF_FFFF, 32'd0);
    // time wraps past zero
    send_beat(KIND_TICK, 32'd5, 32'd0);
    wait_drain();

    // Random phases, each with its own register set and idling mix
    for (int ph = 0; ph < 8; ph++) begin
      choose_regs(ph % 4);
      apply_regs();
      case ((ph + ph / 4) % 4)
        0: begin sender_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin sender_idle_pct = 52; sink_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  sink_stall_pct = 52; end
        default: begin sender_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      for (int n = 0; n < PhaseBeats; n++) begin
        next_random_beat(kind, t, v);
        send_beat(kind, t, v);
        if ($urandom_range(0, 199) == 0) wait_drain();
      end
      wait_drain();
    end

    repeat (5) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("vehicle_health_mode_supervisor_test: clean");
    end else begin
      $display("vehicle_health_mode_supervisor_test: errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/vhms_pkg.sv
sv/vehicle_health_mode_supervisor.sv
tb/sv/vehicle_health_mode_supervisor_checker.sv
tb/sv/vehicle_health_mode_supervisor_test.sv
